/* rtl/hermite_polynomial_evaluator_macros.svh */
// assertion macros for the hermite polynomial evaluator
// used by the checker module, no other dependencies
`ifndef HERMITE_POLYNOMIAL_EVALUATOR_MACROS_SVH
`define HERMITE_POLYNOMIAL_EVALUATOR_MACROS_SVH

// same-cycle implication
`define HPE_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HPE_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/hpe_pkg.sv */
// shared constants, types, microcode rom and saturating arithmetic
// for the hermite polynomial evaluator; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hpe_pkg;

   localparam int MAX_DEGREE = 16;
   localparam int FRAC_BITS  = 12;

   localparam int ROW_LEN   = MAX_DEGREE + 1;
   localparam int TBL_DEPTH = ROW_LEN * ROW_LEN;
   localparam int TBL_AW    = $clog2(TBL_DEPTH);
   localparam int RW        = $clog2(MAX_DEGREE + 2);
   localparam int MW        = $clog2(2 * MAX_DEGREE);
   localparam int MPW       = 65 + MW;
   localparam int SHW       = 64 + FRAC_BITS;

   localparam int DEG_W  = 8;
   localparam int PT_W   = 16;
   localparam int VAL_W  = 64;
   localparam int TD_W   = 5;
   localparam int CSR_IW = 2;
   localparam int CSR_DW = 8;

   localparam int PLO_W  = 33 + PT_W;
   localparam int PHI_W  = 32 + PT_W;
   localparam int PROD_W = PHI_W + 32;

   localparam logic signed [VAL_W-1:0] S64_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] S64_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   localparam logic [CSR_IW-1:0] CSR_TABLE_DEGREE = CSR_IW'(0);
   localparam logic [CSR_IW-1:0] CSR_AUTO_RESIZE  = CSR_IW'(1);

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_AVAIL = 2'd1,
      ST_SAT       = 2'd2
   } status_type;

   typedef struct packed {
      logic [DEG_W-1:0]        degree;
      logic signed [PT_W-1:0]  point;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      status_type              status;
   } rsp_type;

   // datapath actions
   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_ROWINIT,
      OP_FRD,
      OP_FMUL,
      OP_FWR,
      OP_ROWDONE,
      OP_EINIT,
      OP_MLO,
      OP_MHI,
      OP_CMB,
      OP_ADD,
      OP_OUT
   } op_type;

   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_FILL_DONE,
      C_ROW_MORE,
      C_ERR,
      C_K_NZ,
      C_OUT_BUSY
   } cond_type;

   // program addresses
   typedef enum logic [3:0] {
      US_IDLE,
      US_FCHK,
      US_FRD,
      US_FMUL,
      US_FWR,
      US_FNEXT,
      US_ECHK,
      US_MLO,
      US_MHI,
      US_CMB,
      US_ADD,
      US_OUT
   } ustep_type;

   typedef struct packed {
      op_type    op;
      cond_type  wait_cond;
      cond_type  jump_cond;
      ustep_type target;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic fill_done;
      logic row_more;
      logic err;
      logic k_nz;
      logic out_busy;
   } flags_type;

   typedef struct packed {
      logic                    ov;
      logic signed [VAL_W-1:0] value;
   } sat_type;

   // control program: wait holds the step, jump overrides the fall-through
   function automatic ctrl_type ucode_rom(input ustep_type step);
      ctrl_type w;
      case (step)
         US_IDLE:  w = '{OP_ACCEPT,  C_NO_REQ,   C_NEVER,     US_IDLE};
         US_FCHK:  w = '{OP_ROWINIT, C_NEVER,    C_FILL_DONE, US_ECHK};
         US_FRD:   w = '{OP_FRD,     C_NEVER,    C_NEVER,     US_IDLE};
         US_FMUL:  w = '{OP_FMUL,    C_NEVER,    C_NEVER,     US_IDLE};
         US_FWR:   w = '{OP_FWR,     C_NEVER,    C_ROW_MORE,  US_FRD};
         US_FNEXT: w = '{OP_ROWDONE, C_NEVER,    C_ALWAYS,    US_FCHK};
         US_ECHK:  w = '{OP_EINIT,   C_NEVER,    C_ERR,       US_OUT};
         US_MLO:   w = '{OP_MLO,     C_NEVER,    C_NEVER,     US_IDLE};
         US_MHI:   w = '{OP_MHI,     C_NEVER,    C_NEVER,     US_IDLE};
         US_CMB:   w = '{OP_CMB,     C_NEVER,    C_NEVER,     US_IDLE};
         US_ADD:   w = '{OP_ADD,     C_NEVER,    C_K_NZ,      US_MLO};
         US_OUT:   w = '{OP_OUT,     C_OUT_BUSY, C_ALWAYS,    US_IDLE};
         default:  w = '{OP_NOP,     C_NEVER,    C_ALWAYS,    US_IDLE};
      endcase
      return w;
   endfunction

   function automatic sat_type sat_from(input logic sign, input logic fits,
                                        input logic signed [VAL_W-1:0] low);
      sat_type r;
      r.ov    = !fits;
      r.value = fits ? low : (sign ? S64_MIN : S64_MAX);
      return r;
   endfunction

   function automatic sat_type add_sat(input logic signed [VAL_W-1:0] a,
                                       input logic signed [VAL_W-1:0] b);
      logic [VAL_W:0] s;
      s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
      return sat_from(s[VAL_W], s[VAL_W] == s[VAL_W-1], s[VAL_W-1:0]);
   endfunction

   function automatic sat_type sub_sat(input logic signed [VAL_W-1:0] a,
                                       input logic signed [VAL_W-1:0] b);
      logic [VAL_W:0] s;
      s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
      return sat_from(s[VAL_W], s[VAL_W] == s[VAL_W-1], s[VAL_W-1:0]);
   endfunction

   // coefficient scaled into the fixed-point format
   function automatic sat_type shl_sat(input logic signed [VAL_W-1:0] c);
      logic signed [SHW-1:0] w;
      logic                  fits;
      w    = SHW'(c);
      w    = w <<< FRAC_BITS;
      fits = (&w[SHW-1:VAL_W-1]) | ~(|w[SHW-1:VAL_W-1]);
      return sat_from(w[SHW-1], fits, w[VAL_W-1:0]);
   endfunction

   function automatic sat_type mul_small_sat(input logic signed [VAL_W-1:0] a,
                                             input logic [MW-1:0] m);
      logic signed [MPW-1:0] p;
      logic                  fits;
      p    = MPW'(a) * MPW'($signed({1'b0, m}));
      fits = (&p[MPW-1:VAL_W-1]) | ~(|p[MPW-1:VAL_W-1]);
      return sat_from(p[MPW-1], fits, p[VAL_W-1:0]);
   endfunction

   // floor of the product over 2^FRAC_BITS, clamped to 64 bits
   function automatic sat_type fix_sat(input logic signed [PROD_W-1:0] prod);
      logic signed [PROD_W-1:0] q;
      logic                     fits;
      q    = prod >>> FRAC_BITS;
      fits = (&q[PROD_W-1:VAL_W-1]) | ~(|q[PROD_W-1:VAL_W-1]);
      return sat_from(q[PROD_W-1], fits, q[VAL_W-1:0]);
   endfunction

   function automatic logic [TBL_AW-1:0] tbl_addr(input logic [RW-1:0] row,
                                                  input logic [RW-1:0] col);
      logic [TBL_AW-1:0] base;
      base = TBL_AW'(row) * TBL_AW'(ROW_LEN);
      return base + TBL_AW'(col);
   endfunction

endpackage

`default_nettype wire

/* rtl/hermite_polynomial_evaluator.sv */
// top level of the hermite polynomial evaluator: register port, result register
// depends on hpe_pkg, hpe_sequencer and hpe_datapath
`timescale 1ns / 1ps
`default_nettype none

// Returns the physicists' Hermite polynomial H_n(x) for a degree n and a signed
// fixed-point x (FRAC_BITS fraction bits), as a saturated 64-bit fixed-point
// value with a status (ok, degree not available, saturated). One item is in
// flight at a time; a finished result sits in an output register, so the next
// request transfer can start while the result waits to be taken. A short
// microcode program steps a shared datapath: with the needed rows already in
// the coefficient table, the Horner loop takes each coefficient through two
// 32-bit partial multiplies, a rescale and an add. Filling a missing row of
// the table takes each coefficient through the table ram reads, the recurrence
// multiply and the table write, and happens once per row after reset. Register
// writes are always accepted (csr_ready is tied high) and must only be issued
// while the block is idle.
module hermite_polynomial_evaluator (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire hpe_pkg::req_type              req_data,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output hpe_pkg::rsp_type                   rsp_data,
   // register write channel
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [hpe_pkg::CSR_IW-1:0]    csr_index,
   input  wire logic [hpe_pkg::CSR_DW-1:0]    csr_wdata
);

   // configuration registers
   logic [hpe_pkg::TD_W-1:0] table_degree_ff, table_degree_in;
   logic                     auto_resize_ff, auto_resize_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   hpe_pkg::rsp_type         rsp_data_ff, rsp_data_in;

   hpe_pkg::ctrl_type        ctrl;
   hpe_pkg::flags_type       flags;
   hpe_pkg::rsp_type         result;
   logic                     out_load;

   // microcode sequencer
   hpe_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   // table, recurrence and horner datapath
   hpe_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .op           (ctrl.op),
      .req_valid    (req_valid),
      .req_data     (req_data),
      .table_degree (table_degree_ff),
      .auto_resize  (auto_resize_ff),
      .out_busy     (rsp_valid_ff),
      .flags        (flags),
      .out_load     (out_load),
      .result       (result)
   );

   // a request transfer happens only in the idle step of the program
   assign req_ready = (ctrl.op == hpe_pkg::OP_ACCEPT);
   assign csr_ready = 1'b1;

   always_comb begin
      table_degree_in = table_degree_ff;
      auto_resize_in  = auto_resize_ff;
      if (csr_valid) begin
         case (csr_index)
            hpe_pkg::CSR_TABLE_DEGREE: begin
               table_degree_in = csr_wdata[hpe_pkg::TD_W-1:0];
            end
            hpe_pkg::CSR_AUTO_RESIZE: begin
               auto_resize_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end

      // load only into an empty slot, clear on the result transfer
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_degree_ff <= '0;
         auto_resize_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         table_degree_ff <= table_degree_in;
         auto_resize_ff  <= auto_resize_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* rtl/hpe_ram.sv */
// generic ram: one write port, two registered read ports
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module hpe_ram #(
   parameter int DATA_W = 64,
   parameter int DEPTH  = 289
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic                     rd_en_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic      [DATA_W-1:0]        rd_data_a,
   input  wire logic                     rd_en_b,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [DATA_W-1:0]        rd_data_b
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en_a) begin
         rd_a_ff <= mem_ff[rd_addr_a];
      end
      if (rd_en_b) begin
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

/* rtl/hpe_sequencer.sv */
// microcode sequencer: step counter, program rom fetch, wait and jump logic
// depends on hpe_pkg
`timescale 1ns / 1ps
`default_nettype none

module hpe_sequencer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire hpe_pkg::flags_type  flags,
   output hpe_pkg::ctrl_type        ctrl
);

   hpe_pkg::ustep_type upc_ff;
   hpe_pkg::ustep_type upc_in;
   logic [3:0]         upc_inc;
   logic               wait_hit;
   logic               jump_hit;

   function automatic logic cond_true(input hpe_pkg::cond_type c,
                                      input hpe_pkg::flags_type f);
      logic r;
      case (c)
         hpe_pkg::C_NEVER:     r = 1'b0;
         hpe_pkg::C_ALWAYS:    r = 1'b1;
         hpe_pkg::C_NO_REQ:    r = !f.req_valid;
         hpe_pkg::C_FILL_DONE: r = f.fill_done;
         hpe_pkg::C_ROW_MORE:  r = f.row_more;
         hpe_pkg::C_ERR:       r = f.err;
         hpe_pkg::C_K_NZ:      r = f.k_nz;
         hpe_pkg::C_OUT_BUSY:  r = f.out_busy;
         default:              r = 1'b0;
      endcase
      return r;
   endfunction

   always_comb begin
      ctrl     = hpe_pkg::ucode_rom(upc_ff);
      wait_hit = cond_true(ctrl.wait_cond, flags);
      jump_hit = cond_true(ctrl.jump_cond, flags);
      upc_inc  = upc_ff + 4'd1;
      if (wait_hit) begin
         upc_in = upc_ff;
      end else if (jump_hit) begin
         upc_in = ctrl.target;
      end else begin
         upc_in = hpe_pkg::ustep_type'(upc_inc);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= hpe_pkg::US_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/hpe_datapath.sv */
// datapath: coefficient table, row filling recurrence and horner evaluation
// depends on hpe_pkg and hpe_ram
`timescale 1ns / 1ps
`default_nettype none

module hpe_datapath (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire hpe_pkg::op_type            op,
   input  wire logic                       req_valid,
   input  wire hpe_pkg::req_type           req_data,
   input  wire logic [hpe_pkg::TD_W-1:0]   table_degree,
   input  wire logic                       auto_resize,
   input  wire logic                       out_busy,
   output hpe_pkg::flags_type              flags,
   output logic                            out_load,
   output hpe_pkg::rsp_type                result
);

   localparam int RW = hpe_pkg::RW;

   // control state
   logic [RW-1:0] rows_ff, rows_in;

   // item and loop state
   logic [hpe_pkg::DEG_W-1:0]          deg_ff, deg_in;
   logic signed [hpe_pkg::PT_W-1:0]    pt_ff, pt_in;
   logic                               err_ff, err_in;
   logic [RW-1:0]                      fill_tgt_ff, fill_tgt_in;
   logic [RW-1:0]                      k_ff, k_in;
   logic signed [hpe_pkg::VAL_W-1:0]   acc_ff, acc_in;
   logic                               ov_ff, ov_in;
   logic signed [hpe_pkg::PLO_W-1:0]   plo_ff, plo_in;
   logic signed [hpe_pkg::PHI_W-1:0]   phi_ff, phi_in;
   logic signed [hpe_pkg::VAL_W-1:0]   csh_ff, csh_in;
   logic signed [hpe_pkg::VAL_W-1:0]   mres_ff, mres_in;
   logic signed [hpe_pkg::VAL_W-1:0]   c1_ff, c1_in;
   logic signed [hpe_pkg::VAL_W-1:0]   t_ff, t_in;

   // table ports
   logic                          rd_en_a, rd_en_b, wr_en;
   logic [hpe_pkg::TBL_AW-1:0]    rd_addr_a, rd_addr_b, wr_addr;
   logic [hpe_pkg::VAL_W-1:0]     rd_data_a, rd_data_b;
   logic signed [hpe_pkg::VAL_W-1:0] wr_data;

   // working values
   logic [RW-1:0]                 tgt;
   logic                          err_now;
   logic [RW-1:0]                 deg_low;
   logic                          use1, use2;
   logic [RW:0]                   m_wide;
   logic [hpe_pkg::MW-1:0]        m_small;
   logic [hpe_pkg::TBL_AW-1:0]    p1_addr, p2_addr, coef_addr;
   logic signed [hpe_pkg::PROD_W-1:0] prod;
   hpe_pkg::sat_type              s_shl, s_fix, s_add, s_dbl, s_mul, s_sub, s_lim;

   hpe_ram #(
      .DATA_W (hpe_pkg::VAL_W),
      .DEPTH  (hpe_pkg::TBL_DEPTH)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en_a   (rd_en_a),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_en_b   (rd_en_b),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   always_comb begin
      // rows that the table degree setting makes available
      if (int'(table_degree) > hpe_pkg::MAX_DEGREE) begin
         tgt = RW'(hpe_pkg::MAX_DEGREE);
      end else begin
         tgt = RW'(table_degree);
      end
      deg_low = req_data.degree[RW-1:0];
      err_now = (int'(req_data.degree) > hpe_pkg::MAX_DEGREE)
             || (!auto_resize
                 && (req_data.degree > hpe_pkg::DEG_W'(tgt))
                 && (req_data.degree >= hpe_pkg::DEG_W'(rows_ff)));

      // recurrence operands for entry k of row rows_ff
      use1      = (k_ff != '0);
      use2      = ({1'b0, k_ff} + (RW+1)'(2)) <= {1'b0, rows_ff};
      m_wide    = {rows_ff - RW'(1), 1'b0};
      m_small   = m_wide[hpe_pkg::MW-1:0];
      p1_addr   = use1 ? hpe_pkg::tbl_addr(rows_ff - RW'(1), k_ff - RW'(1)) : '0;
      p2_addr   = use2 ? hpe_pkg::tbl_addr(rows_ff - RW'(2), k_ff) : '0;
      coef_addr = hpe_pkg::tbl_addr(deg_ff[RW-1:0], k_ff);

      s_dbl = hpe_pkg::add_sat(rd_data_a, rd_data_a);
      s_mul = hpe_pkg::mul_small_sat(rd_data_b, m_small);
      s_sub = hpe_pkg::sub_sat(c1_ff, t_ff);
      s_lim = hpe_pkg::add_sat(c1_ff, hpe_pkg::S64_MAX);

      // horner arithmetic
      s_shl = hpe_pkg::shl_sat(rd_data_a);
      prod  = $signed({phi_ff, 32'b0})
            + $signed({{(hpe_pkg::PROD_W-hpe_pkg::PLO_W){plo_ff[hpe_pkg::PLO_W-1]}}, plo_ff});
      s_fix = hpe_pkg::fix_sat(prod);
      s_add = hpe_pkg::add_sat(mres_ff, csh_ff);

      // table access
      rd_en_a   = (op == hpe_pkg::OP_FRD) || (op == hpe_pkg::OP_MLO);
      rd_addr_a = (op == hpe_pkg::OP_MLO) ? coef_addr : p1_addr;
      rd_en_b   = (op == hpe_pkg::OP_FRD);
      rd_addr_b = p2_addr;
      wr_en     = (op == hpe_pkg::OP_FWR);
      wr_addr   = hpe_pkg::tbl_addr(rows_ff, k_ff);
      if (rows_ff == '0) begin
         wr_data = hpe_pkg::VAL_W'(1);
      end else if (t_ff == hpe_pkg::S64_MIN) begin
         wr_data = s_lim.value;
      end else begin
         wr_data = s_sub.value;
      end

      rows_in     = rows_ff;
      deg_in      = deg_ff;
      pt_in       = pt_ff;
      err_in      = err_ff;
      fill_tgt_in = fill_tgt_ff;
      k_in        = k_ff;
      acc_in      = acc_ff;
      ov_in       = ov_ff;
      plo_in      = plo_ff;
      phi_in      = phi_ff;
      csh_in      = csh_ff;
      mres_in     = mres_ff;
      c1_in       = c1_ff;
      t_in        = t_ff;
      out_load    = 1'b0;

      case (op)
         hpe_pkg::OP_ACCEPT: begin
            if (req_valid) begin
               deg_in      = req_data.degree;
               pt_in       = req_data.point;
               err_in      = err_now;
               fill_tgt_in = (err_now || (deg_low <= tgt)) ? tgt : deg_low;
            end
         end
         hpe_pkg::OP_ROWINIT: begin
            k_in = '0;
         end
         hpe_pkg::OP_FMUL: begin
            c1_in = use1 ? s_dbl.value : '0;
            t_in  = use2 ? s_mul.value : '0;
         end
         hpe_pkg::OP_FWR: begin
            k_in = k_ff + RW'(1);
         end
         hpe_pkg::OP_ROWDONE: begin
            rows_in = rows_ff + RW'(1);
         end
         hpe_pkg::OP_EINIT: begin
            acc_in = '0;
            ov_in  = 1'b0;
            k_in   = deg_ff[RW-1:0];
         end
         hpe_pkg::OP_MLO: begin
            plo_in = $signed({1'b0, acc_ff[31:0]}) * pt_ff;
         end
         hpe_pkg::OP_MHI: begin
            phi_in = $signed(acc_ff[hpe_pkg::VAL_W-1:32]) * pt_ff;
            csh_in = s_shl.value;
            ov_in  = ov_ff | s_shl.ov;
         end
         hpe_pkg::OP_CMB: begin
            mres_in = s_fix.value;
            ov_in   = ov_ff | s_fix.ov;
         end
         hpe_pkg::OP_ADD: begin
            acc_in = s_add.value;
            ov_in  = ov_ff | s_add.ov;
            k_in   = k_ff - RW'(1);
         end
         hpe_pkg::OP_OUT: begin
            out_load = !out_busy;
         end
         default: begin
         end
      endcase

      flags.req_valid = req_valid;
      flags.fill_done = rows_ff > fill_tgt_ff;
      flags.row_more  = k_ff != rows_ff;
      flags.err       = err_ff;
      flags.k_nz      = k_ff != '0;
      flags.out_busy  = out_busy;

      if (err_ff) begin
         result.value  = '0;
         result.status = hpe_pkg::ST_NOT_AVAIL;
      end else begin
         result.value  = acc_ff;
         result.status = ov_ff ? hpe_pkg::ST_SAT : hpe_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= '0;
      end else begin
         rows_ff <= rows_in;
      end
   end

   always_ff @(posedge clock) begin
      deg_ff      <= deg_in;
      pt_ff       <= pt_in;
      err_ff      <= err_in;
      fill_tgt_ff <= fill_tgt_in;
      k_ff        <= k_in;
      acc_ff      <= acc_in;
      ov_ff       <= ov_in;
      plo_ff      <= plo_in;
      phi_ff      <= phi_in;
      csh_ff      <= csh_in;
      mres_ff     <= mres_in;
      c1_ff       <= c1_in;
      t_ff        <= t_in;
   end

endmodule

`default_nettype wire

/* rtl/hpe_checker.sv */
// port-level checks for the hermite polynomial evaluator, bound to the top level
// depends on hpe_pkg and hermite_polynomial_evaluator_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "hermite_polynomial_evaluator_macros.svh"

module hpe_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire hpe_pkg::rsp_type            rsp_data,
   input wire logic                        csr_valid,
   input wire logic                        csr_ready
);

   // a stalled result keeps its valid and payload
   `HPE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // one item at a time: no request transfer right after another
   `HPE_ASSERT_NXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")

   // an unavailable degree reports a zero value
   `HPE_ASSERT_IMP(a_na_zero, clock, reset, rsp_valid && (rsp_data.status == hpe_pkg::ST_NOT_AVAIL), rsp_data.value == '0, "unavailable degree with non-zero value")

   // register writes are never refused
   `HPE_ASSERT_IMP(a_csr_ready, clock, reset, csr_valid, csr_ready, "register write refused")

endmodule

bind hermite_polynomial_evaluator hpe_checker u_hpe_checker (.*);

`default_nettype wire
